// File: src/lfp_pkg.sv
// ----------------------------------------------------------------------------
// LiDAR frame parser package
// Shared types and constants for the 9-byte frame parser and obstacle flag.
// ----------------------------------------------------------------------------
`default_nettype none

package lfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 4;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_THRESHOLD = 1'b1;

    // Reset values
    localparam logic [BYTE_W-1:0]  HEADER_BYTE_RST   = 8'd89;
    localparam logic [VALUE_W-1:0] THRESHOLD_RST     = 16'd20;
    localparam logic [VALUE_W-1:0] LAST_DISTANCE_RST = 16'hffff;

    // Output tdata width, padded to whole bytes
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [BYTE_W-1:0]  header_byte;
        logic [VALUE_W-1:0] obstacle_threshold;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] distance;
        logic [VALUE_W-1:0] signal_strength;
        logic               obstacle_near;
        logic               checksum_error;
    } result_t;

endpackage : lfp_pkg

`default_nettype wire

// File: src/lfp_frame_parser.sv
// ----------------------------------------------------------------------------
// LiDAR frame parser core
// Tracks the frame position, the running checksum and the assembled fields;
// produces one result when the checksum byte of a frame is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_frame_parser
    import lfp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire cfg_t              cfg,
    output result_t                result
);

    // Frame position codes
    localparam logic [POS_W-1:0] POS_HDR1  = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR2  = 4'd1;
    localparam logic [POS_W-1:0] POS_DIST0 = 4'd2;
    localparam logic [POS_W-1:0] POS_DIST1 = 4'd3;
    localparam logic [POS_W-1:0] POS_STR0  = 4'd4;
    localparam logic [POS_W-1:0] POS_STR1  = 4'd5;
    localparam logic [POS_W-1:0] POS_RSV0  = 4'd6;
    localparam logic [POS_W-1:0] POS_RSV1  = 4'd7;
    localparam logic [POS_W-1:0] POS_CSUM  = 4'd8;

    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [BYTE_W-1:0]  sum_reg,      sum_next;
    logic [VALUE_W-1:0] dist_asm_reg, dist_asm_next;
    logic [VALUE_W-1:0] str_asm_reg,  str_asm_next;
    logic [VALUE_W-1:0] last_dist_reg, last_dist_next;
    logic [VALUE_W-1:0] last_str_reg,  last_str_next;
    logic               bad;
    logic [BYTE_W-1:0]  sum_add;

    assign sum_add = sum_reg + rx_byte;
    assign bad     = (rx_byte != sum_reg);

    always_comb begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        dist_asm_next  = dist_asm_reg;
        str_asm_next   = str_asm_reg;
        last_dist_next = last_dist_reg;
        last_str_next  = last_str_reg;
        result.valid   = 1'b0;
        unique case (pos_reg)
            POS_HDR2: begin
                if (rx_byte == cfg.header_byte) begin
                    sum_next = sum_add;
                    pos_next = POS_DIST0;
                end else begin
                    pos_next = POS_HDR1;
                end
            end
            POS_DIST0: begin
                dist_asm_next = {{(VALUE_W-BYTE_W){1'b0}}, rx_byte};
                sum_next      = sum_add;
                pos_next      = POS_DIST1;
            end
            POS_DIST1: begin
                dist_asm_next = {rx_byte, dist_asm_reg[BYTE_W-1:0]};
                sum_next      = sum_add;
                pos_next      = POS_STR0;
            end
            POS_STR0: begin
                str_asm_next = {{(VALUE_W-BYTE_W){1'b0}}, rx_byte};
                sum_next     = sum_add;
                pos_next     = POS_STR1;
            end
            POS_STR1: begin
                str_asm_next = {rx_byte, str_asm_reg[BYTE_W-1:0]};
                sum_next     = sum_add;
                pos_next     = POS_RSV0;
            end
            POS_RSV0: begin
                sum_next = sum_add;
                pos_next = POS_RSV1;
            end
            POS_RSV1: begin
                sum_next = sum_add;
                pos_next = POS_CSUM;
            end
            POS_CSUM: begin
                if (!bad) begin
                    last_dist_next = dist_asm_reg;
                    last_str_next  = str_asm_reg;
                end
                pos_next     = POS_HDR1;
                result.valid = 1'b1;
            end
            default: begin
                // Hunting the first header; unused codes hunt as well
                if (rx_byte == cfg.header_byte) begin
                    sum_next = rx_byte;
                    pos_next = POS_HDR2;
                end else begin
                    pos_next = POS_HDR1;
                end
            end
        endcase
        result.distance        = last_dist_next;
        result.signal_strength = last_str_next;
        result.obstacle_near   = (last_dist_next <= cfg.obstacle_threshold);
        result.checksum_error  = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_HDR1;
            sum_reg       <= '0;
            dist_asm_reg  <= '0;
            str_asm_reg   <= '0;
            last_dist_reg <= LAST_DISTANCE_RST;
            last_str_reg  <= '0;
        end else if (step) begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            dist_asm_reg  <= dist_asm_next;
            str_asm_reg   <= str_asm_next;
            last_dist_reg <= last_dist_next;
            last_str_reg  <= last_str_next;
        end
    end

endmodule : lfp_frame_parser

`default_nettype wire

// File: src/lfp_out_stage.sv
// ----------------------------------------------------------------------------
// LiDAR frame parser result register
// Holds one result for the master-side stream and reports when it can load.
// ----------------------------------------------------------------------------
`default_nettype none

module lfp_out_stage
    import lfp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire result_t              result,
    output logic                      can_load,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [0:0]                m_tuser
);

    localparam int PAD_W = M_TDATA_W - 2*VALUE_W - 1;

    logic               valid_reg;
    logic [VALUE_W-1:0] dist_reg;
    logic [VALUE_W-1:0] str_reg;
    logic               near_reg;
    logic               err_reg;

    // Free when empty or when the held result transfers this cycle
    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load && result.valid) begin
            dist_reg <= result.distance;
            str_reg  <= result.signal_strength;
            near_reg <= result.obstacle_near;
            err_reg  <= result.checksum_error;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, near_reg, str_reg, dist_reg};
    assign m_tuser  = err_reg;

endmodule : lfp_out_stage

`default_nettype wire

// File: src/lidar_frame_parser_obstacle_core.sv
// ----------------------------------------------------------------------------
// LiDAR 9-byte frame parser with obstacle flag
// Syncs on a doubled header byte, checks the frame checksum and reports the
// latest good distance and strength with a near-obstacle flag.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      per transfer
//  s_*       in   tdata[7:0] rx_byte                           one byte
//  m_*       out  tdata distance/strength/obstacle_near,       one per frame
//                 tuser checksum_error
//  cfg_*     in   index 0 header_byte, 1 obstacle_threshold    one register
//
//  One byte is taken every cycle unless the result register stalls; each byte
//  waits in the input register, and its result, if any, loads as it leaves.
//  The result register is the only stall point: the input register advances
//  whenever the result register is empty or transfers in the same cycle.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_frame_parser_obstacle_core
    import lfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input byte stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] distance,
                                                  // [31:16] signal_strength,
                                                  // [32] obstacle_near, rest 0
    output logic [0:0]                 m_tuser,   // [0] checksum_error
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VALUE_W-1:0]    cfg_wdata
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              can_load;
    logic              step;
    result_t           result;

    // Configuration registers; drop value bits above the register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte        <= HEADER_BYTE_RST;
            cfg_reg.obstacle_threshold <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HEADER_BYTE:        cfg_reg.header_byte <= cfg_wdata[BYTE_W-1:0];
                CFG_OBSTACLE_THRESHOLD: cfg_reg.obstacle_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the held byte into the parser when the result side can take it
    assign step     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload holds until the next accepted transfer
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    lfp_frame_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    lfp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : lidar_frame_parser_obstacle_core

`default_nettype wire
